// ===== sv/audio_frame_ring_with_track_markers_defines.svh =====
// Assertion macros used by the RTL of the audio frame ring.
`ifndef AUDIO_FRAME_RING_WITH_TRACK_MARKERS_DEFINES_SVH
`define AUDIO_FRAME_RING_WITH_TRACK_MARKERS_DEFINES_SVH

`ifndef SYNTHESIS

`define AFRM_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

`define AFRM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`define AFRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define AFRM_ASSERT_ALWAYS(name, expr)
`define AFRM_ASSERT_IMPL(name, ante, cons)
`define AFRM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== sv/afrm_pkg.sv =====
package afrm_pkg;

    localparam int KindBits   = 3;
    localparam int FrameWidth = 32;
    localparam int KeyWidth   = 16;
    localparam int PrefillBits = 13;
    localparam int TotalBits  = 32;
    localparam int InTdataBits = 48;

    localparam logic [PrefillBits-1:0] PREFILL_RESET = 13'd2048;

    localparam logic [KindBits-1:0] KIND_WRITE = 3'd0;
    localparam logic [KindBits-1:0] KIND_PULL  = 3'd1;
    localparam logic [KindBits-1:0] KIND_PLAY  = 3'd2;
    localparam logic [KindBits-1:0] KIND_PAUSE = 3'd3;
    localparam logic [KindBits-1:0] KIND_FLUSH = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_PULL,
        OP_PLAY,
        OP_PAUSE,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [FrameWidth-1:0] frame;
        logic [KeyWidth-1:0]   key;
    } q_item_t;

endpackage

// ===== sv/afrm_front.sv =====
module afrm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: frame_data[31:0], track_key[47:32].
    input  logic [afrm_pkg::InTdataBits-1:0]    s_tdata,
    // s_tuser fields from bit 0: kind[2:0].
    input  logic [afrm_pkg::KindBits-1:0]       s_tuser,
    output logic                                q_valid,
    output afrm_pkg::q_item_t                   q_item,
    input  logic                                q_pop
);
    import afrm_pkg::*;

    q_item_t    q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    q_item_t    in_item;

    always_comb
    begin
        unique case (s_tuser)
            KIND_WRITE: in_item.op = OP_WRITE;
            KIND_PULL:  in_item.op = OP_PULL;
            KIND_PLAY:  in_item.op = OP_PLAY;
            KIND_PAUSE: in_item.op = OP_PAUSE;
            KIND_FLUSH: in_item.op = OP_FLUSH;
            default:    in_item.op = OP_NONE;
        endcase
        in_item.frame = s_tdata[FrameWidth-1:0];
        in_item.key   = s_tdata[FrameWidth+KeyWidth-1:FrameWidth];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== sv/afrm_back.sv =====
`include "audio_frame_ring_with_track_markers_defines.svh"

module afrm_back #(
    parameter int RING_FRAMES  = 4096,
    parameter int MARKER_DEPTH = 16,
    parameter int FRAME_BITS   = 32,
    parameter int FILL_BITS    = $clog2(RING_FRAMES + 1),
    parameter int OUT_BITS     = ((37 + FILL_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  afrm_pkg::q_item_t                   q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: accepted, out_frame[32:1], underrun, track_reached,
    // drained, playing, fill_level from bit 37 up, zero padding.
    output logic [OUT_BITS-1:0]                 m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afrm_pkg::PrefillBits-1:0]    cfg_data
);
    import afrm_pkg::*;

    localparam int AW  = $clog2(RING_FRAMES);
    localparam int CW  = FILL_BITS;
    localparam int SW  = CW + 1;
    localparam int PW  = (CW > PrefillBits) ? CW : PrefillBits;
    localparam int MW  = $clog2(MARKER_DEPTH);
    localparam int MCW = $clog2(MARKER_DEPTH + 1);
    localparam int MSW = MCW + 1;
    localparam int SB  = (FRAME_BITS < FrameWidth) ? FRAME_BITS : FrameWidth;

    logic [SB-1:0]          ring_mem [RING_FRAMES];
    logic [SB-1:0]          ring_rd_reg;
    logic [TotalBits-1:0]   mark_mem [MARKER_DEPTH];
    logic [TotalBits-1:0]   mfront_reg;

    logic [AW-1:0]          rp_reg, rp_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [MW-1:0]          mhead_reg, mhead_next;
    logic [MCW-1:0]         mcount_reg, mcount_next;
    logic [KeyWidth-1:0]    last_key_reg, last_key_next;
    logic [TotalBits-1:0]   wtot_reg, wtot_next;
    logic [TotalBits-1:0]   rtot_reg, rtot_next;
    logic                   has_written_reg, has_written_next;
    logic                   dry_reg, dry_next;
    logic                   playing_reg, playing_next;
    logic                   waiting_reg, waiting_next;
    logic [PrefillBits-1:0] prefill_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_acc_reg, out_acc_next;
    logic                   out_frame_ok_reg, out_frame_ok_next;
    logic                   out_under_reg, out_under_next;
    logic                   out_reached_reg, out_reached_next;
    logic                   out_drained_reg, out_drained_next;

    logic                   ex;
    logic                   ring_full;
    logic                   ring_we;
    logic                   ring_re;
    logic                   mark_we;
    logic [SW-1:0]          wsum;
    logic [AW-1:0]          wpos;
    logic [MSW-1:0]         msum;
    logic [MW-1:0]          mslot;
    logic [CW-1:0]          fill_inc;
    logic [FrameWidth-1:0]  frame_ext;

    assign ex        = q_valid && (!out_valid_reg || m_tready);
    assign q_pop     = ex;
    assign cfg_ready = 1'b1;
    assign ring_full = (fill_reg == CW'(RING_FRAMES));
    assign fill_inc  = fill_reg + CW'(1);

    always_comb
    begin
        wsum  = SW'(rp_reg) + SW'(fill_reg);
        wpos  = (wsum >= SW'(RING_FRAMES)) ? AW'(wsum - SW'(RING_FRAMES)) : AW'(wsum);
        msum  = MSW'(mhead_reg) + MSW'(mcount_reg);
        mslot = (msum >= MSW'(MARKER_DEPTH)) ? MW'(msum - MSW'(MARKER_DEPTH)) : MW'(msum);
    end

    always_comb
    begin
        rp_next           = rp_reg;
        fill_next         = fill_reg;
        mhead_next        = mhead_reg;
        mcount_next       = mcount_reg;
        last_key_next     = last_key_reg;
        wtot_next         = wtot_reg;
        rtot_next         = rtot_reg;
        has_written_next  = has_written_reg;
        dry_next          = dry_reg;
        playing_next      = playing_reg;
        waiting_next      = waiting_reg;
        ring_we           = 1'b0;
        ring_re           = 1'b0;
        mark_we           = 1'b0;
        out_valid_next    = out_valid_reg && !m_tready;
        out_acc_next      = out_acc_reg;
        out_frame_ok_next = out_frame_ok_reg;
        out_under_next    = out_under_reg;
        out_reached_next  = out_reached_reg;
        out_drained_next  = out_drained_reg;

        if (ex)
        begin
            out_valid_next    = 1'b1;
            out_acc_next      = 1'b0;
            out_frame_ok_next = 1'b0;
            out_under_next    = 1'b0;
            out_reached_next  = 1'b0;
            out_drained_next  = 1'b0;
            unique case (q_item.op)
                OP_WRITE:
                begin
                    if (!ring_full)
                    begin
                        ring_we = 1'b1;
                        if (q_item.key != last_key_reg)
                        begin
                            last_key_next = q_item.key;
                            if (mcount_reg != MCW'(MARKER_DEPTH))
                            begin
                                mark_we     = 1'b1;
                                mcount_next = mcount_reg + MCW'(1);
                            end
                        end
                        dry_next         = 1'b0;
                        fill_next        = fill_inc;
                        wtot_next        = wtot_reg + TotalBits'(1);
                        has_written_next = 1'b1;
                        out_acc_next     = 1'b1;
                        if (waiting_reg && (PW'(fill_inc) >= PW'(prefill_reg)))
                        begin
                            waiting_next = 1'b0;
                            playing_next = 1'b1;
                        end
                    end
                end
                OP_PULL:
                begin
                    if (fill_reg != CW'(0))
                    begin
                        ring_re           = 1'b1;
                        out_frame_ok_next = 1'b1;
                        rp_next   = (rp_reg == AW'(RING_FRAMES - 1)) ? AW'(0) : rp_reg + AW'(1);
                        fill_next = fill_reg - CW'(1);
                        if ((mcount_reg != MCW'(0)) && (mfront_reg == rtot_reg))
                        begin
                            mhead_next = (mhead_reg == MW'(MARKER_DEPTH - 1)) ? MW'(0)
                                                                              : mhead_reg + MW'(1);
                            mcount_next      = mcount_reg - MCW'(1);
                            out_reached_next = 1'b1;
                        end
                        rtot_next = rtot_reg + TotalBits'(1);
                    end
                    else
                    begin
                        out_under_next = 1'b1;
                        if (has_written_reg && !dry_reg)
                        begin
                            dry_next         = 1'b1;
                            out_drained_next = 1'b1;
                        end
                    end
                end
                OP_PLAY:
                begin
                    if (!playing_reg)
                    begin
                        if (PW'(fill_reg) >= PW'(prefill_reg))
                        begin
                            waiting_next = 1'b0;
                            playing_next = 1'b1;
                        end
                        else
                        begin
                            waiting_next = 1'b1;
                        end
                    end
                end
                OP_PAUSE:
                begin
                    waiting_next = 1'b0;
                    playing_next = 1'b0;
                end
                OP_FLUSH:
                begin
                    rp_next          = AW'(0);
                    fill_next        = CW'(0);
                    wtot_next        = TotalBits'(0);
                    rtot_next        = TotalBits'(0);
                    has_written_next = 1'b0;
                    last_key_next    = KeyWidth'(0);
                    mhead_next       = MW'(0);
                    mcount_next      = MCW'(0);
                    dry_next         = 1'b0;
                    if (playing_reg)
                    begin
                        playing_next = 1'b0;
                        waiting_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg           <= '0;
            fill_reg         <= '0;
            mhead_reg        <= '0;
            mcount_reg       <= '0;
            last_key_reg     <= '0;
            wtot_reg         <= '0;
            rtot_reg         <= '0;
            has_written_reg  <= 1'b0;
            dry_reg          <= 1'b0;
            playing_reg      <= 1'b0;
            waiting_reg      <= 1'b0;
            prefill_reg      <= PREFILL_RESET;
            out_valid_reg    <= 1'b0;
            out_acc_reg      <= 1'b0;
            out_frame_ok_reg <= 1'b0;
            out_under_reg    <= 1'b0;
            out_reached_reg  <= 1'b0;
            out_drained_reg  <= 1'b0;
        end
        else
        begin
            rp_reg           <= rp_next;
            fill_reg         <= fill_next;
            mhead_reg        <= mhead_next;
            mcount_reg       <= mcount_next;
            last_key_reg     <= last_key_next;
            wtot_reg         <= wtot_next;
            rtot_reg         <= rtot_next;
            has_written_reg  <= has_written_next;
            dry_reg          <= dry_next;
            playing_reg      <= playing_next;
            waiting_reg      <= waiting_next;
            out_valid_reg    <= out_valid_next;
            out_acc_reg      <= out_acc_next;
            out_frame_ok_reg <= out_frame_ok_next;
            out_under_reg    <= out_under_next;
            out_reached_reg  <= out_reached_next;
            out_drained_reg  <= out_drained_next;
            if (cfg_valid && cfg_ready)
            begin
                prefill_reg <= cfg_data;
            end
        end
    end

    // The ring read is registered; it is taken only when a pull executes, so it
    // holds while the output word waits.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wpos] <= q_item.frame[SB-1:0];
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[rp_reg];
        end
    end

    // The front marker is read every cycle at the next head, with the write of
    // the same cycle forwarded.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mslot] <= wtot_reg;
        end
        if (mark_we && (mslot == mhead_next))
        begin
            mfront_reg <= wtot_reg;
        end
        else
        begin
            mfront_reg <= mark_mem[mhead_next];
        end
    end

    always_comb
    begin
        frame_ext = '0;
        if (out_frame_ok_reg)
        begin
            frame_ext[SB-1:0] = ring_rd_reg;
        end
        m_tdata               = '0;
        m_tdata[0]            = out_acc_reg;
        m_tdata[32:1]         = frame_ext;
        m_tdata[33]           = out_under_reg;
        m_tdata[34]           = out_reached_reg;
        m_tdata[35]           = out_drained_reg;
        m_tdata[36]           = playing_reg;
        m_tdata[37 +: CW]     = fill_reg;
    end

    assign m_tvalid = out_valid_reg;

    `AFRM_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CW'(RING_FRAMES))
    `AFRM_ASSERT_ALWAYS(a_marker_bound, mcount_reg <= MCW'(MARKER_DEPTH))
    `AFRM_ASSERT_ALWAYS(a_play_wait_excl, !(playing_reg && waiting_reg))
    `AFRM_ASSERT_NEXT(a_full_write_holds, ex && (q_item.op == OP_WRITE) && ring_full, $stable(fill_reg))
    `AFRM_ASSERT_NEXT(a_result_holds, out_valid_reg && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

// ===== sv/audio_frame_ring_with_track_markers.sv =====
// Audio output ring with prefill gating and track markers.
// Commands arrive as words on the s_ stream: kind in s_tuser (write, pull, play,
// pause, flush), the frame and its track key in s_tdata. Every accepted word
// yields exactly one result word on the m_ stream, in order.
// The prefill level is written on the cfg_ channel, which is always ready; write
// it only while no command is in flight.
// A front stage decodes each word into a two-entry queue; a back stage executes
// one command per cycle, while the output register is free or being taken,
// against the ring and marker memories, and holds its result in that register.
// Throughput is one word per cycle while m_tready stays high. The word enters
// the queue when accepted, and the execute stage then registers its result,
// together with the ring read, in the output register that drives m_tvalid.
// Reset clears pointers, counters and play state and sets the prefill level to
// 2048; ring contents are not cleared and no clearing pass runs.
// When the receiver stalls, the result word holds, the queue fills with up to
// two words, and then s_tready drops until the result is taken.
module audio_frame_ring_with_track_markers #(
    parameter int RING_FRAMES  = 4096,
    parameter int MARKER_DEPTH = 16,
    parameter int FRAME_BITS   = 32,
    localparam int FILL_BITS   = $clog2(RING_FRAMES + 1),
    localparam int OUT_BITS    = ((37 + FILL_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: frame_data[31:0], track_key[47:32].
    input  logic [afrm_pkg::InTdataBits-1:0]    s_tdata,
    // s_tuser fields from bit 0: kind[2:0].
    input  logic [afrm_pkg::KindBits-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: accepted, out_frame[32:1], underrun, track_reached,
    // drained, playing, fill_level from bit 37 up, zero padding.
    output logic [OUT_BITS-1:0]                 m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afrm_pkg::PrefillBits-1:0]    cfg_data
);
    import afrm_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    afrm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    afrm_back #(
        .RING_FRAMES  (RING_FRAMES),
        .MARKER_DEPTH (MARKER_DEPTH),
        .FRAME_BITS   (FRAME_BITS),
        .FILL_BITS    (FILL_BITS),
        .OUT_BITS     (OUT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule
